// ===== rtl/core/bemf_motor_speed_pid_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the back-EMF speed controller.
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BEMF_MOTOR_SPEED_PID_ASSERT_SVH
`define BEMF_MOTOR_SPEED_PID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMSP_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmsp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BMSP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bmsp assertion failed");

`endif

// ===== rtl/core/bmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsp_pkg
// Types, codes and constants shared by the speed controller modules.
// ----------------------------------------------------------------------------
package bmsp_pkg;

   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 32;

   typedef struct packed {
      logic                        start;
      logic signed [MUL_A_W-1:0]   a;
      logic        [MUL_B_W-1:0]   b;
   } mul_cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_N_W-1:0]   dividend;
      logic [DIV_D_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef enum logic [1:0] {
      STATUS_RUN        = 2'd0,
      STATUS_LOW_SUPPLY = 2'd1,
      STATUS_LOW_TARGET = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SUP_MUL, ST_SUP_MUL2, ST_SUP_DIV, ST_MOT_MUL, ST_MOT_MUL2,
      ST_MOT_DIV, ST_FILTER, ST_TARGET, ST_DECIDE, ST_FF_MUL, ST_FF_DIV,
      ST_I_MUL1, ST_I_MUL2, ST_D_MUL1, ST_D_MUL2, ST_D_DIV, ST_P_MUL1,
      ST_P_MUL2, ST_O_MUL, ST_SUM2, ST_SUM3, ST_SAT, ST_DUTY_DIV, ST_OUT
   } ctrl_state_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_KP          = 3'd0;
   localparam logic [2:0] CSR_MAX_TARGET  = 3'd1;
   localparam logic [2:0] CSR_MIN_TARGET  = 3'd2;
   localparam logic [2:0] CSR_MIN_SUPPLY  = 3'd3;
   localparam logic [2:0] CSR_RAMP_STEP   = 3'd4;
   localparam logic [2:0] CSR_VOLT_SHIFT  = 3'd5;
   localparam logic [2:0] CSR_KNOB_SHIFT  = 3'd6;

   // Filter channels.
   localparam int         NUM_FILTERS = 5;
   localparam logic [2:0] FLT_SUPPLY  = 3'd0;
   localparam logic [2:0] FLT_BEMF    = 3'd1;
   localparam logic [2:0] FLT_SPEED   = 3'd2;
   localparam logic [2:0] FLT_KI      = 3'd3;
   localparam logic [2:0] FLT_KD      = 3'd4;

   localparam logic [15:0] SUPPLY_FILTER_RESET = 16'd12000;

   localparam logic [31:0] PIN_FULL_MV = 32'd3300;
   localparam logic [31:0] DIVIDER_NUM = 32'd22200;
   localparam logic [31:0] DIVIDER_DEN = 32'd2200;
   localparam logic [15:0] SUP_FLOOR   = 16'd1000;
   localparam logic [31:0] PID_SCALE   = 32'd16000000;
   localparam logic [31:0] KP_SCALE    = 32'd1000;
   localparam logic [31:0] KD_SCALE    = 32'd1000000;

   localparam logic [15:0] KP_RESET         = 16'd1500;
   localparam logic [15:0] MAX_TARGET_RESET = 16'd30000;
   localparam logic [15:0] MIN_TARGET_RESET = 16'd50;
   localparam logic [15:0] MIN_SUPPLY_RESET = 16'd6000;
   localparam logic [15:0] RAMP_RESET       = 16'd100;
   localparam logic [3:0]  VOLT_SHIFT_RESET = 4'd2;
   localparam logic [3:0]  KNOB_SHIFT_RESET = 4'd3;

   // 64-bit signed add that saturates at the type limits.
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/bmsp_mul.sv =====
// ----------------------------------------------------------------------------
// bmsp_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bmsp_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  bmsp_pkg::mul_cmd_type             cmd,
   output bmsp_pkg::unit_sts_type            sts,
   output logic signed [bmsp_pkg::MUL_A_W-1:0] product
);
   import bmsp_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic signed [MUL_A_W-1:0] acc_ff, acc_in, mcand_ff;
   logic        [MUL_B_W-1:0] mplier_ff;
   logic        [CNT_W-1:0]   cnt_ff;
   logic                      busy_ff, done_ff;

   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff    <= '0;
         mcand_ff  <= cmd.a;
         mplier_ff <= cmd.b;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign product  = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ===== rtl/core/bmsp_div.sv =====
// ----------------------------------------------------------------------------
// bmsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmsp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  bmsp_pkg::div_cmd_type         cmd,
   output bmsp_pkg::unit_sts_type        sts,
   output logic [bmsp_pkg::DIV_N_W-1:0]  quotient
);
   import bmsp_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W-1:0] rem_ff, divisor_ff;
   logic [DIV_D_W:0]   rem_sh;
   logic [DIV_D_W+1:0] trial;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;

   assign rem_sh = {rem_ff, quo_ff[DIV_N_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quo_ff     <= cmd.dividend;
         rem_ff     <= '0;
         divisor_ff <= cmd.divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_D_W+1]) begin
            rem_ff <= trial[DIV_D_W-1:0];
            quo_ff <= {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_D_W-1:0];
            quo_ff <= {quo_ff[DIV_N_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ===== rtl/core/bmsp_ema_bank.sv =====
// ----------------------------------------------------------------------------
// bmsp_ema_bank
// Five shift-EMA filters with residue, one shared update path.
// ----------------------------------------------------------------------------
module bmsp_ema_bank (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      step_en,
   input  logic [2:0]                                idx,
   input  logic [15:0]                               x,
   input  logic [3:0]                                shift,
   output logic [bmsp_pkg::NUM_FILTERS-1:0][15:0]    values
);
   import bmsp_pkg::*;

   logic [NUM_FILTERS-1:0][15:0] value_ff, residue_ff;
   logic signed [18:0]           sum, step;
   logic [15:0]                  mask, value_in, residue_in;

   always_comb begin
      sum        = $signed({3'b000, x}) - $signed({3'b000, value_ff[idx]})
                   + $signed({3'b000, residue_ff[idx]});
      step       = sum >>> shift;
      mask       = (16'd1 << shift) - 16'd1;
      residue_in = sum[15:0] & mask;
      value_in   = value_ff[idx] + step[15:0];
   end

   // Only the supply filter starts at a nonzero value.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= (NUM_FILTERS*16)'(SUPPLY_FILTER_RESET) << (16 * FLT_SUPPLY);
         residue_ff <= '0;
      end else if (step_en) begin
         value_ff[idx]   <= value_in;
         residue_ff[idx] <= residue_in;
      end
   end

   assign values = value_ff;

endmodule

// ===== rtl/core/bemf_motor_speed_pid.sv =====
// ----------------------------------------------------------------------------
// bemf_motor_speed_pid
// Back-EMF motor speed controller: filters, soft-start target, feedforward
// and a PID with anti-windup, computed per control tick.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | five ADC samples, elapsed ms
//  rsp_     | out       | rsp_valid/rsp_stall  | duty, status, target, ff, bemf
//  csr_     | in        | csr_wr_en            | register index and data
//
// One tick is worked through a sequencer that drives a shared bit-serial
// multiplier and a shared restoring divider. A running tick takes 13
// products and up to 5 quotients; a blocked tick stops after 5 products
// and 2 quotients.
// Reset is synchronous and restores the registers and filter state.
// The result sits in an output register, so a stalled result never holds
// up the next input transfer; only the final store waits for it.
// ----------------------------------------------------------------------------
`include "bemf_motor_speed_pid_assert.svh"

module bemf_motor_speed_pid #(
   parameter int ADC_BITS = 12,
   parameter int DUTY_MAX = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ADC_BITS-1:0]           req_supply_adc,
   input  logic [ADC_BITS-1:0]           req_motor_adc,
   input  logic [ADC_BITS-1:0]           req_speed_knob,
   input  logic [ADC_BITS-1:0]           req_ki_knob,
   input  logic [ADC_BITS-1:0]           req_kd_knob,
   input  logic [15:0]                   req_elapsed_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [$clog2(DUTY_MAX+1)-1:0] rsp_pwm_duty,
   output logic [1:0]                    rsp_status,
   output logic [15:0]                   rsp_ramped_target_mv,
   output logic [15:0]                   rsp_feedforward_value,
   output logic [15:0]                   rsp_filtered_bemf_mv,
   input  logic                          csr_wr_en,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_write_data
);
   import bmsp_pkg::*;

   localparam int DUTY_W = $clog2(DUTY_MAX + 1);
   localparam int NEWT_W = 32 - ADC_BITS;
   localparam logic signed [63:0] SAT_HI_LIMIT = 64'(DUTY_MAX) * 64'(PID_SCALE);
   localparam logic signed [63:0] DUTY_ONE     = 64'(PID_SCALE);

   // Configuration registers.
   logic [15:0] kp_ff, max_t_ff, min_t_ff, min_s_ff, ramp_ff;
   logic [3:0]  vsh_ff, ksh_ff;

   // Latched input samples.
   logic [ADC_BITS-1:0] sup_adc_ff, mot_adc_ff, knob_ff, ki_ff, kd_ff;
   logic [15:0]         ms_ff;

   // Tick datapath.
   ctrl_state_type      state_ff, state_in;
   logic                launched_ff;
   logic [2:0]          fidx_ff;
   logic [15:0]         pin_ff, vsup_ff, vmot_ff;
   logic [NEWT_W-1:0]   newt_ff;
   status_type          status_ff;
   logic [15:0]         soft_ff;
   logic [31:0]         ff_ff;
   logic [DUTY_W-1:0]   duty_ff;
   logic signed [63:0]  integ_ff, ip_ff, d_ff, pk_ff, o_ff;
   logic signed [17:0]  prev_ff;
   logic                first_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [DUTY_W-1:0]   rsp_duty_ff;
   status_type          rsp_status_ff;
   logic [15:0]         rsp_target_ff, rsp_ff_ff, rsp_bemf_ff;

   // Unit interfaces.
   mul_cmd_type         mul_cmd;
   div_cmd_type         div_cmd;
   unit_sts_type        mul_sts, div_sts;
   logic signed [63:0]  mul_res;
   logic [63:0]         div_res;
   logic                unit_done;

   // Filters.
   logic [NUM_FILTERS-1:0][15:0] flt;
   logic [15:0]         flt_x, bemf_raw, sup_floor;
   logic [3:0]          flt_shift;

   logic signed [16:0]  err;
   logic signed [17:0]  derr;
   logic signed [33:0]  diff_w, ramp_s;
   logic                blocked, out_free, out_load, sat_hi, sat_lo;
   logic                rsp_no_drive;

   bmsp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .sts     (mul_sts),
      .product (mul_res)
   );

   bmsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .sts      (div_sts),
      .quotient (div_res)
   );

   bmsp_ema_bank u_ema (
      .clock   (clock),
      .reset   (reset),
      .step_en (state_ff == ST_FILTER),
      .idx     (fidx_ff),
      .x       (flt_x),
      .shift   (flt_shift),
      .values  (flt)
   );

   // Back-EMF is floored at zero before filtering.
   assign bemf_raw  = (vsup_ff > vmot_ff) ? vsup_ff - vmot_ff : 16'd0;
   assign flt_shift = (fidx_ff < FLT_SPEED) ? vsh_ff : ksh_ff;
   assign sup_floor = (flt[FLT_SUPPLY] < SUP_FLOOR) ? SUP_FLOOR : flt[FLT_SUPPLY];
   assign err       = $signed({1'b0, soft_ff}) - $signed({1'b0, flt[FLT_BEMF]});
   assign derr      = 18'(err) - prev_ff;
   assign unit_done = mul_sts.done | div_sts.done;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   always_comb begin
      case (fidx_ff)
         FLT_SUPPLY: flt_x = vsup_ff;
         FLT_BEMF:   flt_x = bemf_raw;
         FLT_SPEED:  flt_x = 16'(knob_ff);
         FLT_KI:     flt_x = 16'(ki_ff);
         FLT_KD:     flt_x = 16'(kd_ff);
         default:    flt_x = 16'd0;
      endcase
   end

   // The supply check uses the unfiltered supply; the target check the
   // freshly scaled knob target.
   assign blocked = (vsup_ff <= min_s_ff) || (32'(newt_ff) < 32'(min_t_ff));

   // Soft start: the target moves toward the new value by at most one step.
   always_comb begin
      ramp_s = $signed({18'd0, ramp_ff});
      diff_w = $signed({2'b00, 32'(newt_ff)}) - $signed({18'd0, soft_ff});
      if (diff_w > ramp_s) begin
         diff_w = ramp_s;
      end else if (diff_w < -ramp_s) begin
         diff_w = -ramp_s;
      end
   end

   // Anti-windup: hold the integrator while the output is pinned and the
   // error pushes further into the limit.
   assign sat_hi = (o_ff > SAT_HI_LIMIT) && (err > 17'sd0);
   assign sat_lo = (o_ff < 64'sd0) && (err < 17'sd0);

   // Sequencer: next state and unit commands.
   always_comb begin
      state_in         = state_ff;
      mul_cmd.start    = 1'b0;
      mul_cmd.a        = '0;
      mul_cmd.b        = '0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SUP_MUL;
            end
         end
         ST_SUP_MUL, ST_MOT_MUL: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = (state_ff == ST_SUP_MUL) ? 64'(sup_adc_ff) : 64'(mot_adc_ff);
            mul_cmd.b     = PIN_FULL_MV;
            if (unit_done) begin
               state_in = (state_ff == ST_SUP_MUL) ? ST_SUP_MUL2 : ST_MOT_MUL2;
            end
         end
         ST_SUP_MUL2, ST_MOT_MUL2: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(pin_ff);
            mul_cmd.b     = DIVIDER_NUM;
            if (unit_done) begin
               state_in = (state_ff == ST_SUP_MUL2) ? ST_SUP_DIV : ST_MOT_DIV;
            end
         end
         ST_SUP_DIV, ST_MOT_DIV: begin
            div_cmd.start    = !launched_ff;
            div_cmd.dividend = mul_res;
            div_cmd.divisor  = DIVIDER_DEN;
            if (unit_done) begin
               state_in = (state_ff == ST_SUP_DIV) ? ST_MOT_MUL : ST_FILTER;
            end
         end
         ST_FILTER: begin
            if (fidx_ff == FLT_KD) begin
               state_in = ST_TARGET;
            end
         end
         ST_TARGET: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(flt[FLT_SPEED]);
            mul_cmd.b     = 32'(max_t_ff);
            if (unit_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = blocked ? ST_OUT : ST_FF_MUL;
         end
         ST_FF_MUL: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(soft_ff);
            mul_cmd.b     = 32'(DUTY_MAX);
            if (unit_done) begin
               state_in = ST_FF_DIV;
            end
         end
         ST_FF_DIV: begin
            div_cmd.start    = !launched_ff;
            div_cmd.dividend = mul_res;
            div_cmd.divisor  = 32'(sup_floor);
            if (unit_done) begin
               state_in = ST_I_MUL1;
            end
         end
         ST_I_MUL1: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(err);
            mul_cmd.b     = 32'(flt[FLT_KI]);
            if (unit_done) begin
               state_in = ST_I_MUL2;
            end
         end
         ST_I_MUL2: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = mul_res;
            mul_cmd.b     = 32'(ms_ff);
            if (unit_done) begin
               state_in = ST_D_MUL1;
            end
         end
         ST_D_MUL1: begin
            // No derivative on the first run after reset or a block, or with no time.
            if (first_ff || (ms_ff == 16'd0)) begin
               state_in = ST_P_MUL1;
            end else begin
               mul_cmd.start = !launched_ff;
               mul_cmd.a     = 64'(derr);
               mul_cmd.b     = 32'(flt[FLT_KD]);
               if (unit_done) begin
                  state_in = ST_D_MUL2;
               end
            end
         end
         ST_D_MUL2: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = mul_res;
            mul_cmd.b     = KD_SCALE;
            if (unit_done) begin
               state_in = ST_D_DIV;
            end
         end
         ST_D_DIV: begin
            // Divide the magnitude so the quotient truncates toward zero.
            div_cmd.start    = !launched_ff;
            div_cmd.dividend = mul_res[63] ? 64'(-mul_res) : 64'(mul_res);
            div_cmd.divisor  = 32'(ms_ff);
            if (unit_done) begin
               state_in = ST_P_MUL1;
            end
         end
         ST_P_MUL1: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(err);
            mul_cmd.b     = 32'(kp_ff);
            if (unit_done) begin
               state_in = ST_P_MUL2;
            end
         end
         ST_P_MUL2: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = mul_res;
            mul_cmd.b     = KP_SCALE;
            if (unit_done) begin
               state_in = ST_O_MUL;
            end
         end
         ST_O_MUL: begin
            mul_cmd.start = !launched_ff;
            mul_cmd.a     = 64'(ff_ff);
            mul_cmd.b     = PID_SCALE;
            if (unit_done) begin
               state_in = ST_SUM2;
            end
         end
         ST_SUM2: begin
            state_in = ST_SUM3;
         end
         ST_SUM3: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            // A negative sum gives no drive, so the compare is signed.
            state_in = (o_ff >= DUTY_ONE) ? ST_DUTY_DIV : ST_OUT;
         end
         ST_DUTY_DIV: begin
            div_cmd.start    = !launched_ff;
            div_cmd.dividend = o_ff;
            div_cmd.divisor  = PID_SCALE;
            if (unit_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
         fidx_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_cmd.start || div_cmd.start) begin
            launched_ff <= 1'b1;
         end else if (unit_done) begin
            launched_ff <= 1'b0;
         end
         if (state_ff == ST_FILTER) begin
            fidx_ff <= fidx_ff + 3'd1;
         end else begin
            fidx_ff <= '0;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= KP_RESET;
         max_t_ff <= MAX_TARGET_RESET;
         min_t_ff <= MIN_TARGET_RESET;
         min_s_ff <= MIN_SUPPLY_RESET;
         ramp_ff  <= RAMP_RESET;
         vsh_ff   <= VOLT_SHIFT_RESET;
         ksh_ff   <= KNOB_SHIFT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KP:         kp_ff    <= csr_write_data;
            CSR_MAX_TARGET: max_t_ff <= csr_write_data;
            CSR_MIN_TARGET: min_t_ff <= csr_write_data;
            CSR_MIN_SUPPLY: min_s_ff <= csr_write_data;
            CSR_RAMP_STEP:  ramp_ff  <= csr_write_data;
            CSR_VOLT_SHIFT: vsh_ff   <= csr_write_data[3:0];
            CSR_KNOB_SHIFT: ksh_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Input samples are captured on the transfer.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         sup_adc_ff <= req_supply_adc;
         mot_adc_ff <= req_motor_adc;
         knob_ff    <= req_speed_knob;
         ki_ff      <= req_ki_knob;
         kd_ff      <= req_kd_knob;
         ms_ff      <= req_elapsed_ms;
      end
   end

   // Controller state that persists across ticks.
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff  <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_DECIDE: begin
               if (blocked) begin
                  soft_ff  <= '0;
                  integ_ff <= '0;
                  prev_ff  <= '0;
                  first_ff <= 1'b1;
               end else begin
                  soft_ff <= soft_ff + diff_w[15:0];
               end
            end
            ST_SUM3: begin
               first_ff <= 1'b0;
               prev_ff  <= 18'(err);
            end
            ST_SAT: begin
               if (!(sat_hi || sat_lo)) begin
                  integ_ff <= ip_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Per-tick working values.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SUP_MUL, ST_MOT_MUL: begin
            if (unit_done) begin
               pin_ff <= 16'(mul_res >>> ADC_BITS);
            end
         end
         ST_SUP_DIV: begin
            if (unit_done) begin
               vsup_ff <= div_res[15:0];
            end
         end
         ST_MOT_DIV: begin
            if (unit_done) begin
               vmot_ff <= div_res[15:0];
            end
         end
         ST_TARGET: begin
            if (unit_done) begin
               newt_ff <= NEWT_W'(mul_res >>> ADC_BITS);
            end
         end
         ST_DECIDE: begin
            duty_ff <= '0;
            ff_ff   <= '0;
            d_ff    <= '0;
            if (vsup_ff <= min_s_ff) begin
               status_ff <= STATUS_LOW_SUPPLY;
            end else if (blocked) begin
               status_ff <= STATUS_LOW_TARGET;
            end else begin
               status_ff <= STATUS_RUN;
            end
         end
         ST_FF_DIV: begin
            if (unit_done) begin
               ff_ff <= div_res[31:0];
            end
         end
         ST_I_MUL2: begin
            if (unit_done) begin
               ip_ff <= sadd(integ_ff, mul_res);
            end
         end
         ST_D_DIV: begin
            if (unit_done) begin
               d_ff <= mul_res[63] ? -$signed(div_res) : $signed(div_res);
            end
         end
         ST_P_MUL2: begin
            if (unit_done) begin
               pk_ff <= mul_res;
            end
         end
         ST_O_MUL: begin
            if (unit_done) begin
               o_ff <= sadd(mul_res, pk_ff);
            end
         end
         ST_SUM2: o_ff <= sadd(o_ff, ip_ff);
         ST_SUM3: o_ff <= sadd(o_ff, d_ff);
         ST_DUTY_DIV: begin
            if (unit_done) begin
               duty_ff <= (div_res > 64'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(div_res);
            end
         end
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_duty_ff   <= duty_ff;
         rsp_status_ff <= status_ff;
         rsp_target_ff <= soft_ff;
         rsp_ff_ff     <= (ff_ff > 32'd65535) ? 16'hFFFF : ff_ff[15:0];
         rsp_bemf_ff   <= flt[FLT_BEMF];
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pwm_duty          = rsp_duty_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_ramped_target_mv  = rsp_target_ff;
   assign rsp_feedforward_value = rsp_ff_ff;
   assign rsp_filtered_bemf_mv  = rsp_bemf_ff;

   assign rsp_no_drive = (rsp_pwm_duty == '0) && (rsp_feedforward_value == 16'd0)
                         && (rsp_ramped_target_mv == 16'd0);

   // A unit is only started when it is free, and the two never overlap.
   `BMSP_ASSERT_IMPL(a_mul_start_free, mul_cmd.start, !mul_sts.busy)
   `BMSP_ASSERT_IMPL(a_div_start_free, div_cmd.start, !div_sts.busy)
   `BMSP_ASSERT_IMPL(a_units_exclusive, mul_sts.busy, !div_sts.busy)
   // A blocked result carries no drive.
   `BMSP_ASSERT_IMPL(a_blocked_idle, rsp_valid && (rsp_status != STATUS_RUN), rsp_no_drive)
   // A taken result leaves the register unless a new one is stored.
   `BMSP_ASSERT_NEXT(a_rsp_drains, rsp_valid && !rsp_stall && (state_ff != ST_OUT), !rsp_valid)

endmodule
